### rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int FUNC_W = 2;
    localparam int S_TDATA_W = 48;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [PRIO_W-1:0]        prio;
    } t_entry;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] data;
        logic [PRIO_W-1:0]        prio;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] head;
        logic                     refused;
    } t_res;

endpackage

`default_nettype wire

### rtl/sorted_priority_queue.sv
// Sorted priority queue, top level: sequencer, entry store, output register.
// Depends on spq_pkg, spq_ctrl and spq_mem.
//
//  channel   direction  signals                     transaction
//  s (req)   in         i_s_tvalid/o_s_tready        one operation
//  m (res)   out        o_m_tvalid/i_m_tready        one result per operation
//
// The sequencer moves one entry a cycle through the store: an insert shifts up every held
//   entry with priority equal or greater, a remove shifts down every entry behind the head,
//   and a refused operation, a peek or an insert into an empty queue moves none.
// Synchronous active-low reset empties the queue; the store itself is not cleared.
// A waiting result sits in the output register; the next operation is taken
// meanwhile, and a finished one holds in the sequencer until the register frees.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1),
    localparam int M_TDATA_W = ((DATA_W + 3 + CW + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output      logic                 o_s_tready,
    // [31:0] item_data, [47:32] item_priority
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // [1:0] func
    input  wire logic [FUNC_W-1:0]    i_s_tuser,
    output      logic                 o_m_tvalid,
    input  wire logic                 i_m_tready,
    // [31:0] head_data, [32] refused, [33] now_empty, [34] now_full,
    // then occupancy, zero padded
    output      logic [M_TDATA_W-1:0] o_m_tdata
);

    t_req          req;
    t_res          res;
    logic          res_valid, res_ready;
    logic [CW-1:0] count;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_entry        wr_entry, rd_entry;

    logic          r_out_valid;
    t_res          r_out_res;
    logic [CW-1:0] r_out_count;
    logic          out_empty, out_full;

    assign req = '{func: i_s_tuser,
                   data: i_s_tdata[DATA_W-1:0],
                   prio: i_s_tdata[DATA_W+PRIO_W-1:DATA_W]};

    spq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_count     (count),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_entry  (wr_entry),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_entry  (rd_entry)
    );

    spq_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry)
    );

    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_res   <= res;
            r_out_count <= count;
        end
    end

    assign out_empty = (r_out_count == '0);
    assign out_full  = (r_out_count == CW'(DEPTH));

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'({r_out_count, out_full, out_empty,
                                    r_out_res.refused, r_out_res.head});

endmodule

`default_nettype wire

### rtl/spq_mem.sv
// Entry store: one write port and one registered read port.
// Depends on spq_pkg for the entry type.
`default_nettype none

module spq_mem
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_entry,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output      t_entry        o_rd_entry
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

`default_nettype wire

### rtl/spq_ctrl.sv
// Sequencer: insert by shifting entries up from the tail, remove by
// shifting down from the head, one entry per cycle. Depends on spq_pkg.
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output      logic          o_req_ready,
    input  wire t_req          i_req,
    output      logic          o_res_valid,
    input  wire logic          i_res_ready,
    output      t_res          o_res,
    output      logic [CW-1:0] o_count,
    output      logic          o_wr_en,
    output      logic [AW-1:0] o_wr_addr,
    output      t_entry        o_wr_entry,
    output      logic          o_rd_en,
    output      logic [AW-1:0] o_rd_addr,
    input  wire t_entry        i_rd_entry
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_REM  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;
    t_req          r_req, n_req;
    t_res          r_res, n_res;

    logic [CW-1:0] k_m1, k_m2, k_p1, cnt_m1;
    t_entry        new_entry;

    assign k_m1   = r_k - 1'b1;
    assign k_m2   = r_k - CW'(2);
    assign k_p1   = r_k + 1'b1;
    assign cnt_m1 = r_count - 1'b1;
    assign new_entry = '{data: r_req.data, prio: r_req.prio};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_k        = r_k;
        n_req      = r_req;
        n_res      = r_res;
        o_wr_en    = 1'b0;
        o_wr_addr  = '0;
        o_wr_entry = new_entry;
        o_rd_en    = 1'b0;
        o_rd_addr  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req = i_req;
                    n_res = '{head: '0, refused: 1'b0};
                    n_state = S_DONE;
                    if (i_req.func == FUNC_INSERT) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res.refused = 1'b1;
                        end else if (r_count == '0) begin
                            o_wr_en    = 1'b1;
                            o_wr_entry = '{data: i_req.data, prio: i_req.prio};
                            n_count    = r_count + 1'b1;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = cnt_m1[AW-1:0];
                            n_k       = r_count;
                            n_state   = S_INS;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.refused = 1'b1;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = '0;
                            n_state   = S_HEAD;
                        end
                    end
                end
            end
            S_INS: begin
                // read data is entry k-1
                o_wr_en   = 1'b1;
                o_wr_addr = r_k[AW-1:0];
                if (i_rd_entry.prio >= r_req.prio) begin
                    o_wr_entry = i_rd_entry;
                    n_k        = k_m1;
                    if (k_m1 == '0) begin
                        n_state = S_HEAD;
                        n_req.func = FUNC_INSERT;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = k_m2[AW-1:0];
                    end
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_HEAD: begin
                if (r_req.func == FUNC_INSERT) begin
                    // new entry goes to the head slot
                    o_wr_en   = 1'b1;
                    o_wr_addr = '0;
                    n_count   = r_count + 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_res.head = i_rd_entry.data;
                    n_state    = S_DONE;
                    if (r_req.func == FUNC_REMOVE) begin
                        if (r_count == CW'(1)) begin
                            n_count = '0;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = AW'(1);
                            n_k       = CW'(1);
                            n_state   = S_REM;
                        end
                    end
                end
            end
            S_REM: begin
                // read data is entry k
                o_wr_en    = 1'b1;
                o_wr_addr  = k_m1[AW-1:0];
                o_wr_entry = i_rd_entry;
                if (k_p1 < r_count) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = k_p1[AW-1:0];
                    n_k       = k_p1;
                end else begin
                    n_count = cnt_m1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_req <= n_req;
        r_res <= n_res;
    end

    assign o_req_ready = i_rst_n && (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
    assign o_count     = r_count;

endmodule

`default_nettype wire

### rtl/spq_checker.sv
// Port-level checks for sorted_priority_queue, attached by bind.
// Depends on spq_pkg for field widths.
`default_nettype none

module spq_port_checks
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int M_TDATA_W = ((DATA_W + 3 + CW + 7) / 8) * 8
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] i_m_tdata
);

    logic [DATA_W-1:0] head;
    logic              refused, empty, full;
    logic [CW-1:0]     occ;

    assign head    = i_m_tdata[DATA_W-1:0];
    assign refused = i_m_tdata[DATA_W];
    assign empty   = i_m_tdata[DATA_W+1];
    assign full    = i_m_tdata[DATA_W+2];
    assign occ     = i_m_tdata[DATA_W+3+CW-1:DATA_W+3];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && refused |-> head == '0)
        else $error("refused result carries data");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (empty == (occ == '0)) && (full == (occ == CW'(DEPTH)))
                       && (occ <= CW'(DEPTH)))
        else $error("status flags disagree with occupancy");

endmodule

bind sorted_priority_queue spq_port_checks #(.DEPTH(DEPTH)) u_spq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

`default_nettype wire

### sim/spq_checker.sv
// Checker for the sorted priority queue: watches both stream channels, predicts each
// result from its own copy of the sorted store and compares it with what the block returns.
// Depends on spq_pkg.
module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int M_TDATA_W = ((DATA_W + 3 + CW + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    // [31:0] item_data, [47:32] item_priority
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // [1:0] func
    input  wire logic [FUNC_W-1:0]    i_s_tuser,
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    // [31:0] head_data, [32] refused, [33] now_empty, [34] now_full, then occupancy
    input  wire logic [M_TDATA_W-1:0] i_m_tdata,
    output int                        o_errors,
    output int                        o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] head;
        logic                     refused;
        logic                     now_empty;
        logic                     now_full;
        logic [CW-1:0]            occupancy;
    } t_outcome;

    t_entry   queue_slots [DEPTH];
    int       slots_used;
    t_outcome due_results [$];

    function automatic t_outcome serve_op(input logic [FUNC_W-1:0] func, input t_entry item);
        t_outcome res;
        int       pos;
        int       k;
        res = '0;
        if (func == FUNC_INSERT) begin
            if (slots_used >= DEPTH) begin
                res.refused = 1'b1;
            end else begin
                pos = 0;
                while (pos < slots_used && queue_slots[pos].prio < item.prio)
                    pos++;
                for (k = slots_used; k > pos; k--)
                    queue_slots[k] = queue_slots[k - 1];
                queue_slots[pos] = item;
                slots_used++;
            end
        end else if (func == FUNC_REMOVE) begin
            if (slots_used == 0) begin
                res.refused = 1'b1;
            end else begin
                res.head = queue_slots[0].data;
                for (k = 1; k < slots_used; k++)
                    queue_slots[k - 1] = queue_slots[k];
                slots_used--;
            end
        end else begin
            // peek; the spare code acts the same
            if (slots_used == 0)
                res.refused = 1'b1;
            else
                res.head = queue_slots[0].data;
        end
        res.now_empty = (slots_used == 0);
        res.now_full  = (slots_used >= DEPTH);
        res.occupancy = slots_used[CW-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        t_entry   item;
        if (!i_rst_n) begin
            slots_used = 0;
            due_results.delete();
        end else begin
            // results first: a transaction accepted this edge cannot answer at the same edge
            if (i_m_tvalid && i_m_tready) begin
                got.head      = i_m_tdata[DATA_W-1:0];
                got.refused   = i_m_tdata[DATA_W];
                got.now_empty = i_m_tdata[DATA_W + 1];
                got.now_full  = i_m_tdata[DATA_W + 2];
                got.occupancy = i_m_tdata[DATA_W + 3 +: CW];
                if (due_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: result with none pending: head %0d refused %0b empty %0b full %0b occ %0d",
                                 $time, got.head, got.refused, got.now_empty, got.now_full,
                                 got.occupancy);
                end else begin
                    want = due_results.pop_front();
                    if (got.head !== want.head || got.refused !== want.refused ||
                        got.now_empty !== want.now_empty || got.now_full !== want.now_full ||
                        got.occupancy !== want.occupancy) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("%0t: mismatch, expected head %0d refused %0b empty %0b full %0b occ %0d",
                                     $time, want.head, want.refused, want.now_empty,
                                     want.now_full, want.occupancy);
                            $display("%0t:           actual   head %0d refused %0b empty %0b full %0b occ %0d",
                                     $time, got.head, got.refused, got.now_empty,
                                     got.now_full, got.occupancy);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                item.data = i_s_tdata[DATA_W-1:0];
                item.prio = i_s_tdata[DATA_W +: PRIO_W];
                due_results.push_back(serve_op(i_s_tuser, item));
            end
        end
        o_pending = due_results.size();
    end

endmodule

### sim/sorted_priority_queue_test.sv
// Testbench top for the sorted priority queue: clock, reset, request stimulus and
// result back-pressure; checking is done by spq_checker. Depends on spq_pkg and the RTL.
module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int DEPTH = 16;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int M_TDATA_W = ((DATA_W + 3 + CW + 7) / 8) * 8;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic [FUNC_W-1:0]    i_s_tuser = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;

    int   mismatches;
    int   pending;
    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;
    logic rx_hold_req = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sorted_priority_queue #(.DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    spq_checker #(.DEPTH(DEPTH)) u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .o_errors   (mismatches),
        .o_pending  (pending)
    );

    task automatic issue_op(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] data,
                            input logic [PRIO_W-1:0] prio);
        while (!tx_calm && $urandom_range(99) < 34) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {prio, data};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // ins_pct/rem_pct split the mix; the rest are peeks and spare-code peeks
    task automatic random_ops(input int count, input int ins_pct, input int rem_pct,
                              input int prio_max);
        int                  pick;
        logic [FUNC_W-1:0]   func;
        logic [PRIO_W-1:0]   prio;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < ins_pct)
                func = FUNC_INSERT;
            else if (pick < ins_pct + rem_pct)
                func = FUNC_REMOVE;
            else if ($urandom_range(3) == 0)
                func = FUNC_SPARE;
            else
                func = FUNC_PEEK;
            case ($urandom_range(15))
                0: prio = '0;
                1: prio = '1;
                default: prio = PRIO_W'($urandom_range(prio_max));
            endcase
            issue_op(func, $urandom, prio);
        end
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (rx_calm) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 34);
            end
        end
    end

    initial begin
        #4000000;
        $display("sorted_priority_queue_test: errors");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store: every read op is refused
        issue_op(FUNC_PEEK, 32'h1234_5678, 16'h0001);
        issue_op(FUNC_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        issue_op(FUNC_SPARE, 32'h0, 16'h0);
        // fill with extremes and ties; newest of equal priority is served first
        issue_op(FUNC_INSERT, 32'h7FFF_FFFF, 16'h0000);
        issue_op(FUNC_INSERT, 32'h8000_0000, 16'hFFFF);
        issue_op(FUNC_INSERT, 32'h0000_0001, 16'h0000);
        issue_op(FUNC_INSERT, 32'hFFFF_FFFF, 16'h8000);
        issue_op(FUNC_PEEK, 32'h0, 16'h0);
        issue_op(FUNC_INSERT, 32'h0000_0000, 16'h8000);
        issue_op(FUNC_INSERT, 32'h5555_5555, 16'h7FFF);
        issue_op(FUNC_INSERT, 32'hAAAA_AAAA, 16'hFFFF);
        issue_op(FUNC_INSERT, 32'h0F0F_0F0F, 16'h0001);
        for (int n = 0; n < 8; n++)
            issue_op(FUNC_INSERT, $urandom, 16'h4000 + n[15:0]);
        issue_op(FUNC_INSERT, 32'hDEAD_BEEF, 16'h0000);  // full: refused
        issue_op(FUNC_SPARE, 32'h0, 16'h0);
        issue_op(FUNC_REMOVE, 32'h0, 16'h0);

        random_ops(150, 50, 30, 65535);

        tx_calm = 1'b1;
        rx_calm = 1'b1;
        random_ops(150, 50, 35, 7);
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        random_ops(120, 75, 15, 15);

        // receiver holds off while requests keep coming, so the block backs up
        rx_hold_req = 1'b1;
        random_ops(60, 80, 10, 65535);

        drain_results();

        random_ops(150, 20, 65, 65535);
        random_ops(250, 45, 40, 255);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("sorted_priority_queue_test: clean");
        else
            $display("sorted_priority_queue_test: errors");
        $finish;
    end

endmodule
